@@ hw/rtl/sprite_animation_pool_macros.svh @@
// Assertion macros for the sprite animation pool.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef SPRITE_ANIMATION_POOL_MACROS_SVH
`define SPRITE_ANIMATION_POOL_MACROS_SVH

// The consequence must hold in the same cycle as the antecedent.
`define SAP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define SAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sap_pkg.sv @@
// Shared types, widths and codes of the sprite animation pool.
// No dependencies; every file of the block but sap_ram and the macros header imports this package.
`default_nettype none

package sap_pkg;

  localparam int POOL_SIZE  = 16;
  localparam int ADDR_W     = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

  localparam int ACTION_W   = 2;
  localparam int SLOT_W     = 4;
  localparam int DIM_W      = 8;
  localparam int FRAME_W    = 8;
  localparam int TIME_W     = 20;
  localparam int WANT_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 20;

  // Whole periods in one advance fit one bit more than a time value.
  localparam int STEPS_W    = TIME_W + 1;
  localparam int DVD_W      = STEPS_W + 1;
  localparam int DVS_W      = TIME_W;
  localparam int DIV_CNT_W  = $clog2(DVD_W + 1);

  localparam logic [TIME_W-1:0] PERIOD_RST = TIME_W'(125000);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_MODE = CFG_IDX_W'(1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_CREATE    = 2'd0,
    ACT_ADVANCE   = 2'd1,
    ACT_SET_FRAME = 2'd2,
    ACT_UNKNOWN   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_SLOT = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  // Mode 3 can be configured: time still drains but the frame never moves.
  typedef enum logic [1:0] {
    MODE_ONCE     = 2'd0,
    MODE_LOOP     = 2'd1,
    MODE_PINGPONG = 2'd2,
    MODE_STILL    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REC_RAM       = 2'd0,
    REC_CREATE    = 2'd1,
    REC_SET_FRAME = 2'd2
  } rec_src_t;

  typedef enum logic [1:0] {
    RES_BLANK  = 2'd0,
    RES_SLOT   = 2'd1,
    RES_RECORD = 2'd2
  } res_kind_t;

  typedef struct packed {
    logic               sheet;
    mode_t              mode;
    logic               fin;
    logic               fwd;
    logic [TIME_W-1:0]  accum;
    logic [FRAME_W-1:0] total;
    logic [FRAME_W-1:0] frame;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  typedef struct packed {
    logic      latch_item;
    logic      rd_en;
    logic      load_rec;
    rec_src_t  rec_src;
    logic      set_active;
    logic      div_start;
    logic      div_second;
    logic      take_div1;
    logic      apply_direct;
    logic      apply_div2;
    logic      wr_en;
    logic      out_load;
    status_t   res_status;
    res_kind_t res_kind;
  } sap_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic is_create;
    logic pool_full;
    logic is_unknown;
    logic slot_bad;
    logic is_advance;
    logic adv_skip;
    logic total_zero;
    logic need_div2;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sap_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/sap_in_if.sv @@
// Request channel into the sprite animation pool.
// Depends on sap_pkg for the field widths.
`default_nettype none

interface sap_in_if;
  import sap_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ACTION_W-1:0]       action;
  logic [SLOT_W-1:0]         slot;
  logic                      sheet_valid;
  logic [DIM_W-1:0]          sheet_cols;
  logic [DIM_W-1:0]          sheet_rows;
  logic [TIME_W-1:0]         elapsed_us;
  logic signed [WANT_W-1:0]  wanted_frame;

  modport source (
    output valid, action, slot, sheet_valid, sheet_cols, sheet_rows, elapsed_us,
           wanted_frame,
    input  ready
  );

  modport sink (
    input  valid, action, slot, sheet_valid, sheet_cols, sheet_rows, elapsed_us,
           wanted_frame,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/sap_out_if.sv @@
// Result channel out of the sprite animation pool.
// Depends on sap_pkg for the field widths.
`default_nettype none

interface sap_out_if;
  import sap_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic [FRAME_W-1:0]  frame_out;
  logic                finished_out;

  modport source (
    output valid, status, slot_out, frame_out, finished_out,
    input  ready
  );

  modport sink (
    input  valid, status, slot_out, frame_out, finished_out,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/sap_cfg_if.sv @@
// Configuration write channel of the sprite animation pool.
// Depends on sap_pkg for the index and data widths.
`default_nettype none

interface sap_cfg_if;
  import sap_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (
    output valid, reg_index, wdata,
    input  ready
  );

  modport sink (
    input  valid, reg_index, wdata,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/sap_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module sap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/sap_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on sap_pkg for the operand widths.
`default_nettype none

module sap_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [sap_pkg::DVD_W-1:0] dividend,
  input  logic [sap_pkg::DVS_W-1:0] divisor,
  output logic                     busy,
  output logic                     done,
  output logic [sap_pkg::DVD_W-1:0] quotient,
  output logic [sap_pkg::DVS_W-1:0] remainder
);
  import sap_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DVS_W:0]       trial;
  logic                 fits;

  // The partial remainder stays below the divisor, so the trial is one bit wider.
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DVD_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      rem_nxt = fits ? DVS_W'(trial - {1'b0, dvs_r}) : trial[DVS_W-1:0];
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

@@ hw/rtl/sap_datapath.sv @@
// Datapath of the sprite animation pool: item and config registers, slot RAM,
// active bits, free-slot search, divider and the output register.
// Depends on sap_pkg, sap_ram and sap_div.
`default_nettype none

module sap_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sap_pkg::sap_cmd_t              cmd,
  output sap_pkg::sap_stat_t             stat,
  input  logic                           in_valid,
  input  logic [sap_pkg::ACTION_W-1:0]   in_action,
  input  logic [sap_pkg::SLOT_W-1:0]     in_slot,
  input  logic                           in_sheet_valid,
  input  logic [sap_pkg::DIM_W-1:0]      in_sheet_cols,
  input  logic [sap_pkg::DIM_W-1:0]      in_sheet_rows,
  input  logic [sap_pkg::TIME_W-1:0]     in_elapsed_us,
  input  logic signed [sap_pkg::WANT_W-1:0] in_wanted_frame,
  input  logic                           cfg_we,
  input  logic [sap_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sap_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sap_pkg::STATUS_W-1:0]   out_status,
  output logic [sap_pkg::SLOT_W-1:0]     out_slot,
  output logic [sap_pkg::FRAME_W-1:0]    out_frame,
  output logic                           out_finished
);
  import sap_pkg::*;

  // Configuration.
  logic [TIME_W-1:0] period_r;
  mode_t             mode_r;

  // Item registers.
  action_t                 action_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [ADDR_W-1:0]       addr_r;
  logic                    full_r;
  logic                    slot_bad_r;
  logic                    sheet_valid_r;
  logic [DIM_W-1:0]        cols_r;
  logic [DIM_W-1:0]        rows_r;
  logic [TIME_W-1:0]       elapsed_r;
  logic signed [WANT_W-1:0] want_r;

  logic [POOL_SIZE-1:0] active_r;

  slot_rec_t          rec_r, rec_nxt;
  logic [STEPS_W-1:0] steps_r;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic [FRAME_W-1:0]   out_frame_r;
  logic                 out_fin_r;

  logic [ADDR_W-1:0] free_idx;
  logic              free_found;
  logic [ADDR_W-1:0] in_addr;
  logic              in_range;

  logic [REC_W-1:0]   ram_rdata;
  slot_rec_t          rd_rec;
  slot_rec_t          create_rec;
  logic [2*DIM_W-1:0] prod;
  logic [FRAME_W-1:0] clamp_frame;

  logic [FRAME_W-1:0] total_m1;
  logic [FRAME_W-1:0] avail;
  logic [FRAME_W:0]   cyc;
  logic [FRAME_W:0]   phase;
  logic [FRAME_W:0]   q9;

  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_busy, div_done;
  logic [DVD_W-1:0] div_quo;
  logic [DVS_W-1:0] div_rem;

  // Lowest free slot.
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_idx   = ADDR_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign in_addr  = ADDR_W'(in_slot);
  assign in_range = (32'(in_slot) < POOL_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RST;
      mode_r   <= MODE_LOOP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_PERIOD: period_r <= cfg_data[TIME_W-1:0];
        REG_DEFAULT_MODE: mode_r   <= mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      action_r      <= action_t'(in_action);
      full_r        <= !free_found;
      slot_bad_r    <= !in_range || !active_r[in_addr];
      sheet_valid_r <= in_sheet_valid;
      cols_r        <= in_sheet_cols;
      rows_r        <= in_sheet_rows;
      elapsed_r     <= in_elapsed_us;
      want_r        <= in_wanted_frame;
      if (action_t'(in_action) == ACT_CREATE) begin
        addr_r <= free_idx;
        slot_r <= SLOT_W'(free_idx);
      end else begin
        addr_r <= in_addr;
        slot_r <= in_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else if (cmd.set_active) begin
      active_r[addr_r] <= 1'b1;
    end
  end

  sap_ram #(
    .WIDTH (REC_W),
    .DEPTH (POOL_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (addr_r),
    .wdata (rec_r),
    .re    (cmd.rd_en),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  assign rd_rec = ram_rdata;

  // New slot record.
  assign prod = (2*DIM_W)'(cols_r) * (2*DIM_W)'(rows_r);
  always_comb begin
    create_rec       = '0;
    create_rec.sheet = sheet_valid_r;
    create_rec.mode  = mode_r;
    create_rec.fwd   = 1'b1;
    create_rec.total = (|prod[2*DIM_W-1:FRAME_W]) ? '1 : prod[FRAME_W-1:0];
  end

  // Clamp of the requested frame into 0 .. total-1.
  always_comb begin
    if (want_r[WANT_W-1]) begin
      clamp_frame = '0;
    end else if (want_r[WANT_W-2:0] >= (WANT_W-1)'(rd_rec.total)) begin
      clamp_frame = rd_rec.total - FRAME_W'(1);
    end else begin
      clamp_frame = want_r[FRAME_W-1:0];
    end
  end

  // Frame stepping terms.
  assign total_m1 = rec_r.total - FRAME_W'(1);
  assign avail    = total_m1 - rec_r.frame;
  assign cyc      = {total_m1, 1'b0};
  assign phase    = rec_r.fwd ? {1'b0, rec_r.frame} : (cyc - {1'b0, rec_r.frame});
  assign q9       = div_rem[FRAME_W:0];

  always_comb begin
    if (cmd.div_second) begin
      if (rec_r.mode == MODE_LOOP) begin
        div_dvd = DVD_W'(rec_r.frame) + DVD_W'(steps_r);
        div_dvs = DVS_W'(rec_r.total);
      end else begin
        div_dvd = DVD_W'(phase) + DVD_W'(steps_r);
        div_dvs = DVS_W'(cyc);
      end
    end else begin
      div_dvd = DVD_W'({1'b0, rd_rec.accum} + {1'b0, elapsed_r});
      div_dvs = period_r;
    end
  end

  sap_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    rec_nxt = rec_r;
    if (cmd.load_rec) begin
      case (cmd.rec_src)
        REC_CREATE: rec_nxt = create_rec;
        REC_SET_FRAME: begin
          rec_nxt       = rd_rec;
          rec_nxt.frame = clamp_frame;
          rec_nxt.accum = '0;
        end
        default: rec_nxt = rd_rec;
      endcase
    end else if (cmd.take_div1) begin
      rec_nxt.accum = div_rem;
    end else if (cmd.apply_direct) begin
      if ((steps_r != '0) && (rec_r.total != '0)) begin
        case (rec_r.mode)
          MODE_ONCE: begin
            if (steps_r > STEPS_W'(avail)) begin
              rec_nxt.frame = total_m1;
              rec_nxt.fin   = 1'b1;
            end else begin
              rec_nxt.frame = rec_r.frame + steps_r[FRAME_W-1:0];
            end
          end
          MODE_PINGPONG: begin
            // A single-frame ping-pong stays on frame zero.
            if (rec_r.total == FRAME_W'(1)) begin
              rec_nxt.frame = '0;
            end
          end
          default: ;
        endcase
      end
    end else if (cmd.apply_div2) begin
      if (rec_r.mode == MODE_LOOP) begin
        rec_nxt.frame = q9[FRAME_W-1:0];
      end else if (q9 <= {1'b0, total_m1}) begin
        rec_nxt.frame = q9[FRAME_W-1:0];
        rec_nxt.fwd   = 1'b1;
      end else begin
        rec_nxt.frame = FRAME_W'(cyc - q9);
        rec_nxt.fwd   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    if (cmd.take_div1) begin
      steps_r <= div_quo[STEPS_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.res_status;
      case (cmd.res_kind)
        RES_SLOT: begin
          out_slot_r  <= slot_r;
          out_frame_r <= '0;
          out_fin_r   <= 1'b0;
        end
        RES_RECORD: begin
          out_slot_r  <= slot_r;
          out_frame_r <= rec_r.frame;
          out_fin_r   <= rec_r.fin;
        end
        default: begin
          out_slot_r  <= '0;
          out_frame_r <= '0;
          out_fin_r   <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_slot     = out_slot_r;
  assign out_frame    = out_frame_r;
  assign out_finished = out_fin_r;

  always_comb begin
    stat            = '0;
    stat.in_valid   = in_valid;
    stat.is_create  = (action_r == ACT_CREATE);
    stat.pool_full  = full_r;
    stat.is_unknown = (action_r == ACT_UNKNOWN);
    stat.slot_bad   = slot_bad_r;
    stat.is_advance = (action_r == ACT_ADVANCE);
    stat.adv_skip   = !rd_rec.sheet || (period_r == '0) || rd_rec.fin;
    stat.total_zero = (rd_rec.total == '0);
    stat.need_div2  = (steps_r != '0) && (rec_r.total != '0) &&
                      ((rec_r.mode == MODE_LOOP) ||
                       ((rec_r.mode == MODE_PINGPONG) && (rec_r.total != FRAME_W'(1))));
    stat.div_busy   = div_busy;
    stat.div_done   = div_done;
    stat.out_free   = !out_valid_r || out_ready;
  end

endmodule

`default_nettype wire

@@ hw/rtl/sap_ctrl.sv @@
// Controller state machine of the sprite animation pool.
// Depends on sap_pkg and the assertion macros header.
`default_nettype none
`include "sprite_animation_pool_macros.svh"

module sap_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  sap_pkg::sap_stat_t stat,
  output sap_pkg::sap_cmd_t  cmd,
  output logic               in_ready
);
  import sap_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_READ   = 8'b0000_0010,
    S_EVAL   = 8'b0000_0100,
    S_DIV1   = 8'b0000_1000,
    S_STEP   = 8'b0001_0000,
    S_DIV2   = 8'b0010_0000,
    S_WRITE  = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_t;

  state_t    state_r, state_nxt;
  status_t   res_status_r, res_status_nxt;
  res_kind_t res_kind_r, res_kind_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_kind_nxt   = res_kind_r;
    cmd            = '0;
    cmd.rec_src    = REC_RAM;
    cmd.res_status = res_status_r;
    cmd.res_kind   = res_kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (stat.in_valid) begin
          cmd.latch_item = 1'b1;
          state_nxt      = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.load_rec = 1'b1;
        if (stat.is_create) begin
          if (stat.pool_full) begin
            res_status_nxt = ST_FULL;
            res_kind_nxt   = RES_BLANK;
            state_nxt      = S_RESULT;
          end else begin
            cmd.rec_src    = REC_CREATE;
            cmd.set_active = 1'b1;
            res_status_nxt = ST_DONE;
            res_kind_nxt   = RES_RECORD;
            state_nxt      = S_WRITE;
          end
        end else if (stat.is_unknown) begin
          res_status_nxt = ST_IGNORED;
          res_kind_nxt   = RES_SLOT;
          state_nxt      = S_RESULT;
        end else if (stat.slot_bad) begin
          res_status_nxt = ST_BAD_SLOT;
          res_kind_nxt   = RES_SLOT;
          state_nxt      = S_RESULT;
        end else if (stat.is_advance) begin
          res_kind_nxt = RES_RECORD;
          if (stat.adv_skip) begin
            res_status_nxt = ST_IGNORED;
            state_nxt      = S_RESULT;
          end else begin
            cmd.div_start  = 1'b1;
            res_status_nxt = ST_DONE;
            state_nxt      = S_DIV1;
          end
        end else begin
          res_kind_nxt = RES_RECORD;
          if (stat.total_zero) begin
            res_status_nxt = ST_IGNORED;
            state_nxt      = S_RESULT;
          end else begin
            cmd.rec_src    = REC_SET_FRAME;
            res_status_nxt = ST_DONE;
            state_nxt      = S_WRITE;
          end
        end
      end
      S_DIV1: begin
        if (stat.div_done) begin
          cmd.take_div1 = 1'b1;
          state_nxt     = S_STEP;
        end
      end
      S_STEP: begin
        if (stat.need_div2) begin
          cmd.div_start  = 1'b1;
          cmd.div_second = 1'b1;
          state_nxt      = S_DIV2;
        end else begin
          cmd.apply_direct = 1'b1;
          state_nxt        = S_WRITE;
        end
      end
      S_DIV2: begin
        cmd.div_second = 1'b1;
        if (stat.div_done) begin
          cmd.apply_div2 = 1'b1;
          state_nxt      = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_en = 1'b1;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      res_status_r <= ST_DONE;
      res_kind_r   <= RES_BLANK;
    end else begin
      state_r      <= state_nxt;
      res_status_r <= res_status_nxt;
      res_kind_r   <= res_kind_nxt;
    end
  end

  `SAP_ASSERT_NOW(a_div_start_idle, cmd.div_start, !stat.div_busy, "divider started while busy")
  `SAP_ASSERT_NOW(a_out_load_free, cmd.out_load, stat.out_free, "output register overwritten")
  `SAP_ASSERT_NEXT(a_one_item, cmd.latch_item, !in_ready, "second request taken during work")

endmodule

`default_nettype wire

@@ hw/rtl/sprite_animation_pool.sv @@
// Top level of the sprite animation pool: controller plus datapath.
// Depends on sap_pkg, the channel interfaces, sap_ctrl and sap_datapath.
`default_nettype none

// The pool holds POOL_SIZE sprite animation slots and serves one request at a
// time. A create request takes the lowest free slot, an advance request adds
// elapsed microseconds and steps the frame once per whole frame period in
// once, loop or ping-pong mode, and a set-frame request clamps the frame and
// clears the slot's accumulated time. Every request gives exactly one result.
// Slot records live in a small RAM with a registered read; only the active
// bits are flip-flops, and reset clears them all together, so no clearing
// pass is needed. Every request is taken, read from the RAM and evaluated. A
// pool-full, bad-slot, unknown or ignored request then goes straight to its
// result, and a create or set-frame request writes its record back first. An
// advance whose frame needs no wrap (once mode, mode 3, a single-frame
// ping-pong, an empty sheet or no whole period) runs the shared restoring
// divider once, and one in loop or multi-frame ping-pong mode runs it twice,
// before it writes back. The divider retires one quotient bit per cycle over
// 22 bits, first for the time division by the frame period and then for the
// wrap of the frame counter. A result that finds the output register still
// occupied waits until the sink takes the earlier one. The next request is
// taken as soon as the result sits in the output register, even while the sink
// has not yet taken it. Configuration writes are accepted in every cycle and
// must only be issued while the pool is idle.

module sprite_animation_pool (
  input logic       clk,
  input logic       rst_n,
  sap_in_if.sink    in_ch,
  sap_out_if.source out_ch,
  sap_cfg_if.sink   cfg_ch
);
  import sap_pkg::*;

  sap_cmd_t  cmd;
  sap_stat_t stat;
  logic      in_ready;

  // The configuration registers take a write in any cycle.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  sap_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  sap_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_valid        (in_ch.valid),
    .in_action       (in_ch.action),
    .in_slot         (in_ch.slot),
    .in_sheet_valid  (in_ch.sheet_valid),
    .in_sheet_cols   (in_ch.sheet_cols),
    .in_sheet_rows   (in_ch.sheet_rows),
    .in_elapsed_us   (in_ch.elapsed_us),
    .in_wanted_frame (in_ch.wanted_frame),
    .cfg_we          (cfg_ch.valid),
    .cfg_index       (cfg_ch.reg_index),
    .cfg_data        (cfg_ch.wdata),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_slot        (out_ch.slot_out),
    .out_frame       (out_ch.frame_out),
    .out_finished    (out_ch.finished_out)
  );

endmodule

`default_nettype wire
